@@ hdl/mlfq_pkg.sv @@
`default_nettype none
package mlfq_pkg;

  localparam int unsigned IdW    = 5;
  localparam int unsigned IdNum  = 32;
  localparam int unsigned LvlW   = 2;
  localparam int unsigned LvlNum = 3;
  localparam int unsigned CfgW   = 16;

  localparam logic [LvlW-1:0] LVL_LOW = 2'd0;
  localparam logic [LvlW-1:0] LVL_MID = 2'd1;
  localparam logic [LvlW-1:0] LVL_TOP = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NOTHING  = 2'd2;
  localparam logic [1:0] STATUS_REJECTED = 2'd3;

  localparam logic [1:0] CFG_ALLOTMENT = 2'd0;
  localparam logic [1:0] CFG_BOOST     = 2'd1;
  localparam logic [1:0] CFG_TOTAL     = 2'd2;

  localparam logic [1:0]  ALLOT_RST = 2'd2;
  localparam logic [7:0]  BOOST_RST = 8'd10;
  localparam logic [15:0] TOTAL_RST = 16'd100;

  typedef struct packed {
    logic            latch;
    logic            reject;
    logic            load_push;
    logic            tick_begin;
    logic            su_clear_run;
    logic            mv_rd;
    logic [LvlW-1:0] mv_from;
    logic            mv_wr;
    logic [LvlW-1:0] mv_to;
    logic            mv_clr;
    logic            set_top;
    logic            cur_dec_chk;
    logic            slice_inc;
    logic            disp_sel;
    logic            disp_rd;
    logic            disp_su_rd;
    logic            disp_wr;
    logic            out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic              is_tick;
    logic              done;
    logic              run_valid;
    logic              boost_hit;
    logic              su_ge_limit;
    logic [LvlW-1:0]   cur_level;
    logic [LvlNum-1:0] cnt_nz;
    logic              slice_fin;
    logic              none_ready;
    logic              out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ hdl/mlfq_tick_scheduler.sv @@
`default_nettype none
// channel | handshake            | payload
// in      | in_valid_i/in_ready_o | command_i, task_id_i
// out     | out_valid_o/out_ready_i | switched_o .. status_o
// cfg     | cfg_we_i             | cfg_idx_i, cfg_wdata_i
// A load pushes onto the top queue; a tick requeues the running task at
// its level or one lower, counts the slice and dispatches, or dispatches
// only if none runs; a boost lifts lower tasks to the top one by one.
// Output stalls add on; the queue store has one read and one write port.
// Reset clears pointers, counts and control; queue and slice stores hold.
// One item at a time; a result waits in the output register while the
// next item is accepted, and a second result waits until that transfer.
module mlfq_tick_scheduler
  import mlfq_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            command_i,
  input  wire logic [IdW-1:0]  task_id_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 switched_o,
  output logic [IdW-1:0]       stopped_task_o,
  output logic                 stop_valid_o,
  output logic [IdW-1:0]       started_task_o,
  output logic [LvlW-1:0]      started_level_o,
  output logic                 finished_o,
  output logic [1:0]           status_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mlfq_control u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mlfq_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (command_i),
    .task_id_i       (task_id_i),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .switched_o      (switched_o),
    .stopped_task_o  (stopped_task_o),
    .stop_valid_o    (stop_valid_o),
    .started_task_o  (started_task_o),
    .started_level_o (started_level_o),
    .finished_o      (finished_o),
    .status_o        (status_o)
  );

  a_run_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.run_valid && stat.done))
    else $error("running task after finish");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while busy");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stop_valid_o |-> stopped_task_o == '0)
    else $error("stopped task without stop");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && switched_o |-> started_level_o != 2'd3)
    else $error("bad started level");

endmodule
`default_nettype wire

@@ hdl/mlfq_datapath.sv @@
`default_nettype none
module mlfq_datapath
  import mlfq_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  input  wire logic            command_i,
  input  wire logic [IdW-1:0]  task_id_i,
  input  wire logic            out_ready_i,
  input  wire dp_cmd_t         cmd_i,
  output dp_stat_t             stat_o,
  output logic                 out_valid_o,
  output logic                 switched_o,
  output logic [IdW-1:0]       stopped_task_o,
  output logic                 stop_valid_o,
  output logic [IdW-1:0]       started_task_o,
  output logic [LvlW-1:0]      started_level_o,
  output logic                 finished_o,
  output logic [1:0]           status_o
);

  localparam int unsigned PtrW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam int unsigned SumW = CntW + 2;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TASKS);

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    logic [PtrW:0] s;
    s = {1'b0, p} + 1'b1;
    return (s >= (PtrW+1)'(MAX_TASKS)) ? '0 : s[PtrW-1:0];
  endfunction

  logic [1:0]  allot_q;
  logic [7:0]  boost_period_q;
  logic [15:0] total_q;

  logic [PtrW-1:0] heads_q  [LvlNum];
  logic [PtrW-1:0] tails_q  [LvlNum];
  logic [CntW-1:0] counts_q [LvlNum];
  logic [LvlW-1:0] cur_q;
  logic [7:0]      boost_cnt_q;
  logic [15:0]     slices_q;
  logic            run_valid_q;
  logic [IdW-1:0]  run_task_q;
  logic            done_q;
  logic            boost_hit_q;
  logic            cmd_q;
  logic [IdW-1:0]  id_q;

  logic [IdW-1:0] qmem  [LvlNum][MAX_TASKS];
  logic [1:0]     sumem [IdNum];
  logic [IdW-1:0] q_rd_q;
  logic [1:0]     su_rd_q;

  logic            r_switched_q, r_stop_valid_q, r_finished_q;
  logic [IdW-1:0]  r_stopped_q, r_started_q;
  logic [LvlW-1:0] r_level_q;
  logic [1:0]      r_status_q;

  logic            q_we, q_re, su_we, su_re;
  logic [LvlW-1:0] q_wlvl, q_rlvl;
  logic [PtrW-1:0] q_wptr, q_rptr;
  logic [IdW-1:0]  q_wdata, su_waddr, su_raddr;
  logic [1:0]      su_wdata;
  logic [LvlNum-1:0] cnt_nz;
  logic [SumW-1:0] total_cnt;
  logic [7:0]      bc_inc;
  logic [15:0]     sl_inc;
  logic [LvlW-1:0] sel_lvl;
  logic            to_room;

  always_comb begin
    for (int l = 0; l < LvlNum; l++) begin
      cnt_nz[l] = counts_q[l] != '0;
    end
  end

  assign total_cnt = SumW'(counts_q[0]) + SumW'(counts_q[1]) + SumW'(counts_q[2]);
  assign bc_inc    = boost_cnt_q + 8'd1;
  assign sl_inc    = slices_q + 16'd1;
  assign to_room   = counts_q[cmd_i.mv_to] < CntMax;

  always_comb begin
    priority if (cnt_nz[cur_q]) sel_lvl = cur_q;
    else if (cnt_nz[LVL_TOP])   sel_lvl = LVL_TOP;
    else if (cnt_nz[LVL_MID])   sel_lvl = LVL_MID;
    else if (cnt_nz[LVL_LOW])   sel_lvl = LVL_LOW;
    else                        sel_lvl = cur_q;
  end

  always_comb begin
    q_we     = 1'b0;
    q_wlvl   = LVL_TOP;
    q_wptr   = tails_q[LVL_TOP];
    q_wdata  = id_q;
    q_re     = 1'b0;
    q_rlvl   = cur_q;
    q_rptr   = heads_q[cur_q];
    su_we    = 1'b0;
    su_waddr = id_q;
    su_wdata = 2'd0;
    su_re    = 1'b0;
    su_raddr = run_task_q;
    if (cmd_i.load_push && total_cnt < SumW'(MAX_TASKS)) begin
      q_we  = 1'b1;
      su_we = 1'b1;
    end
    if (cmd_i.tick_begin) su_re = 1'b1;
    if (cmd_i.su_clear_run) begin
      su_we    = 1'b1;
      su_waddr = run_task_q;
    end
    if (cmd_i.mv_rd) begin
      q_re   = 1'b1;
      q_rlvl = cmd_i.mv_from;
      q_rptr = heads_q[cmd_i.mv_from];
    end
    if (cmd_i.mv_wr) begin
      q_we    = to_room;
      q_wlvl  = cmd_i.mv_to;
      q_wptr  = tails_q[cmd_i.mv_to];
      q_wdata = q_rd_q;
      su_we    = cmd_i.mv_clr;
      su_waddr = q_rd_q;
    end
    if (cmd_i.disp_rd) q_re = 1'b1;
    if (cmd_i.disp_su_rd) begin
      su_re    = 1'b1;
      su_raddr = q_rd_q;
    end
    if (cmd_i.disp_wr) begin
      su_we    = 1'b1;
      su_waddr = q_rd_q;
      su_wdata = (su_rd_q == 2'd3) ? 2'd3 : su_rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) qmem[q_wlvl][q_wptr] <= q_wdata;
    if (q_re) q_rd_q <= qmem[q_rlvl][q_rptr];
    if (su_we) sumem[su_waddr] <= su_wdata;
    if (su_re) su_rd_q <= sumem[su_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q          <= command_i;
      id_q           <= task_id_i;
      r_switched_q   <= 1'b0;
      r_stop_valid_q <= 1'b0;
      r_stopped_q    <= '0;
      r_started_q    <= '0;
      r_level_q      <= '0;
      r_finished_q   <= 1'b0;
      r_status_q     <= STATUS_OK;
    end
    if (cmd_i.reject) r_status_q <= STATUS_REJECTED;
    if (cmd_i.load_push && total_cnt >= SumW'(MAX_TASKS)) r_status_q <= STATUS_FULL;
    if (cmd_i.tick_begin) begin
      r_stop_valid_q <= 1'b1;
      r_stopped_q    <= run_task_q;
    end
    if (cmd_i.slice_inc && sl_inc >= total_q) r_finished_q <= 1'b1;
    if (cmd_i.disp_sel && !(|cnt_nz)) r_status_q <= STATUS_NOTHING;
    if (cmd_i.disp_wr) begin
      r_switched_q <= 1'b1;
      r_started_q  <= q_rd_q;
      r_level_q    <= cur_q;
    end
    if (cmd_i.out_load) begin
      switched_o      <= r_switched_q;
      stopped_task_o  <= r_stopped_q;
      stop_valid_o    <= r_stop_valid_q;
      started_task_o  <= r_started_q;
      started_level_o <= r_level_q;
      finished_o      <= r_finished_q;
      status_o        <= r_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allot_q        <= ALLOT_RST;
      boost_period_q <= BOOST_RST;
      total_q        <= TOTAL_RST;
      for (int l = 0; l < LvlNum; l++) begin
        heads_q[l]  <= '0;
        tails_q[l]  <= '0;
        counts_q[l] <= '0;
      end
      cur_q       <= LVL_TOP;
      boost_cnt_q <= '0;
      slices_q    <= '0;
      run_valid_q <= 1'b0;
      run_task_q  <= '0;
      done_q      <= 1'b0;
      boost_hit_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ALLOTMENT: allot_q        <= cfg_wdata_i[1:0];
          CFG_BOOST:     boost_period_q <= cfg_wdata_i[7:0];
          CFG_TOTAL:     total_q        <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.load_push && total_cnt < SumW'(MAX_TASKS)) begin
        tails_q[LVL_TOP]  <= next_slot(tails_q[LVL_TOP]);
        counts_q[LVL_TOP] <= counts_q[LVL_TOP] + 1'b1;
      end
      if (cmd_i.tick_begin) begin
        boost_hit_q <= bc_inc >= boost_period_q;
        boost_cnt_q <= (bc_inc >= boost_period_q) ? 8'd0 : bc_inc;
      end
      if (cmd_i.mv_rd) begin
        heads_q[cmd_i.mv_from]  <= next_slot(heads_q[cmd_i.mv_from]);
        counts_q[cmd_i.mv_from] <= counts_q[cmd_i.mv_from] - 1'b1;
      end
      if (cmd_i.mv_wr && to_room) begin
        tails_q[cmd_i.mv_to]  <= next_slot(tails_q[cmd_i.mv_to]);
        counts_q[cmd_i.mv_to] <= counts_q[cmd_i.mv_to] + 1'b1;
      end
      if (cmd_i.set_top) cur_q <= LVL_TOP;
      if (cmd_i.cur_dec_chk && !cnt_nz[cur_q]) cur_q <= cur_q - 1'b1;
      if (cmd_i.slice_inc) begin
        slices_q <= sl_inc;
        if (sl_inc >= total_q) begin
          for (int l = 0; l < LvlNum; l++) begin
            heads_q[l]  <= '0;
            tails_q[l]  <= '0;
            counts_q[l] <= '0;
          end
          done_q      <= 1'b1;
          run_valid_q <= 1'b0;
        end
      end
      if (cmd_i.disp_sel) begin
        cur_q <= sel_lvl;
        if (!(|cnt_nz)) run_valid_q <= 1'b0;
      end
      if (cmd_i.disp_wr) begin
        run_task_q  <= q_rd_q;
        run_valid_q <= 1'b1;
      end
      if (cmd_i.out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  assign stat_o.is_tick     = cmd_q;
  assign stat_o.done        = done_q;
  assign stat_o.run_valid   = run_valid_q;
  assign stat_o.boost_hit   = boost_hit_q;
  assign stat_o.su_ge_limit = su_rd_q >= allot_q;
  assign stat_o.cur_level   = cur_q;
  assign stat_o.cnt_nz      = cnt_nz;
  assign stat_o.slice_fin   = sl_inc >= total_q;
  assign stat_o.none_ready  = !(|cnt_nz);
  assign stat_o.out_busy    = out_valid_o && !out_ready_i;

endmodule
`default_nettype wire

@@ hdl/mlfq_control.sv @@
`default_nettype none
module mlfq_control
  import mlfq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_DECODE = 15'h0002,
    S_LOAD   = 15'h0004,
    S_T_SU   = 15'h0008,
    S_T_DEC  = 15'h0010,
    S_MV_RD  = 15'h0020,
    S_MV_WR  = 15'h0040,
    S_LIFT   = 15'h0080,
    S_POST   = 15'h0100,
    S_DEC    = 15'h0200,
    S_SLICE  = 15'h0400,
    S_D_SEL  = 15'h0800,
    S_D_RD   = 15'h1000,
    S_D_SU   = 15'h2000,
    S_D_WR   = 15'h4000
  } state_e;

  state_e          state_q, state_d, ret_q, ret_d;
  logic [LvlW-1:0] from_q, from_d, to_q, to_d;
  logic            clr_q, clr_d, top_dem_q, top_dem_d, out_pend_q, out_pend_d;

  assign in_ready_o = (state_q == S_IDLE) && !out_pend_q;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    ret_d      = ret_q;
    from_d     = from_q;
    to_d       = to_q;
    clr_d      = clr_q;
    top_dem_d  = top_dem_q;
    out_pend_d = out_pend_q;
    cmd_o.mv_from = from_q;
    cmd_o.mv_to   = to_q;
    cmd_o.mv_clr  = clr_q;
    if (out_pend_q && !stat_i.out_busy) begin
      cmd_o.out_load = 1'b1;
      out_pend_d     = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat_i.done) begin
          cmd_o.reject = 1'b1;
          out_pend_d   = 1'b1;
          state_d      = S_IDLE;
        end else if (!stat_i.is_tick) state_d = S_LOAD;
        else if (!stat_i.run_valid)   state_d = S_D_SEL;
        else                          state_d = S_T_SU;
      end
      S_LOAD: begin
        cmd_o.load_push = 1'b1;
        out_pend_d      = 1'b1;
        state_d         = S_IDLE;
      end
      S_T_SU: begin
        cmd_o.tick_begin = 1'b1;
        state_d          = S_T_DEC;
      end
      S_T_DEC: begin
        clr_d   = 1'b0;
        state_d = S_MV_RD;
        from_d  = stat_i.cur_level;
        to_d    = stat_i.cur_level;
        ret_d   = S_SLICE;
        if (stat_i.boost_hit) begin
          if (stat_i.cur_level == LVL_TOP && stat_i.su_ge_limit) begin
            cmd_o.su_clear_run = 1'b1;
            top_dem_d          = 1'b1;
            state_d            = S_LIFT;
          end else begin
            top_dem_d = 1'b0;
            ret_d     = S_LIFT;
          end
        end else if (stat_i.cur_level != LVL_LOW && stat_i.su_ge_limit) begin
          cmd_o.su_clear_run = 1'b1;
          to_d               = stat_i.cur_level - 1'b1;
          ret_d              = S_DEC;
        end
      end
      S_MV_RD: begin
        if (stat_i.cnt_nz[from_q]) begin
          cmd_o.mv_rd = 1'b1;
          state_d     = S_MV_WR;
        end else begin
          state_d = ret_q;
        end
      end
      S_MV_WR: begin
        cmd_o.mv_wr = 1'b1;
        state_d     = ret_q;
      end
      S_LIFT: begin
        ret_d = S_LIFT;
        to_d  = LVL_TOP;
        clr_d = 1'b1;
        priority if (stat_i.cnt_nz[LVL_MID]) begin
          from_d  = LVL_MID;
          state_d = S_MV_RD;
        end else if (stat_i.cnt_nz[LVL_LOW]) begin
          from_d  = LVL_LOW;
          state_d = S_MV_RD;
        end else begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        if (top_dem_q) begin
          from_d  = LVL_TOP;
          to_d    = LVL_MID;
          clr_d   = 1'b0;
          ret_d   = S_SLICE;
          state_d = S_MV_RD;
        end else begin
          cmd_o.set_top = 1'b1;
          state_d       = S_SLICE;
        end
      end
      S_DEC: begin
        cmd_o.cur_dec_chk = 1'b1;
        state_d           = S_SLICE;
      end
      S_SLICE: begin
        cmd_o.slice_inc = 1'b1;
        if (stat_i.slice_fin) begin
          out_pend_d = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_D_SEL;
        end
      end
      S_D_SEL: begin
        cmd_o.disp_sel = 1'b1;
        if (stat_i.none_ready) begin
          out_pend_d = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_D_RD;
        end
      end
      S_D_RD: begin
        cmd_o.disp_rd = 1'b1;
        state_d       = S_D_SU;
      end
      S_D_SU: begin
        cmd_o.disp_su_rd = 1'b1;
        state_d          = S_D_WR;
      end
      S_D_WR: begin
        cmd_o.disp_wr = 1'b1;
        out_pend_d    = 1'b1;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_SLICE;
      from_q     <= LVL_TOP;
      to_q       <= LVL_TOP;
      clr_q      <= 1'b0;
      top_dem_q  <= 1'b0;
      out_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      from_q     <= from_d;
      to_q       <= to_d;
      clr_q      <= clr_d;
      top_dem_q  <= top_dem_d;
      out_pend_q <= out_pend_d;
    end
  end

endmodule
`default_nettype wire
